// ----- rtl/bdpc_pkg.sv -----
`default_nettype none

package bdpc_pkg;

  localparam int TimeW    = 32;
  localparam int CfgW     = 16;
  localparam int InDataW  = 40;
  localparam int OutDataW = 8;

  // Register reset values
  localparam logic [CfgW-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CfgW-1:0] LONG_PRESS_RESET = 16'd1000;

  // Register indexes
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  typedef struct packed {
    logic             raw_level;
    logic [TimeW-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic stable_level;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_window_ms;
    logic [CfgW-1:0] hold_limit_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/button_debounce_press_classifier.sv -----
`default_nettype none
// Path: an accepted sample request is captured in the input register, then
//   classified into the result register once the result stream can take it.
// Throughput: one sample per cycle unless the result stream stalls;
//   debounce/hold use two 32-bit subtracts and three compares in one classify stage.
// Reset: synchronous rst returns both levels to released, clears times and
//   the long-press flag, and loads debounce 50 ms and long press 1000 ms.

module button_debounce_press_classifier (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [bdpc_pkg::InDataW-1:0]  s_tdata,  // [0] raw_level, [32:1] time_ms,
                                                 // [39:33] zero
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [bdpc_pkg::OutDataW-1:0] m_tdata,  // [0] short_press, [1] long_press,
                                                 // [2] stable_level, [7:3] zero
  // register writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import bdpc_pkg::*;

  logic [CfgW-1:0] debounce_window_ms;
  logic [CfgW-1:0] hold_limit_ms;
  cfg_t            cfg;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    pop;
  result_t result;

  // Register file: writes land immediately, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_window_ms <= DEBOUNCE_RESET;
      hold_limit_ms      <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_window_ms <= cfg_wdata;
        REG_LONG_PRESS: hold_limit_ms      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.debounce_window_ms = debounce_window_ms;
  assign cfg.hold_limit_ms      = hold_limit_ms;

  // Unpack the sample request.
  assign s_item.raw_level = s_tdata[0];
  assign s_item.time_ms   = s_tdata[TimeW:1];

  bdpc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop)
  );

  // Classify one sample per cycle unless the result stream stalls; a downstream
  // stall holds the result register and backs up into the input register.
  bdpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (item_valid),
    .in_item    (item),
    .in_pop     (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {5'b0, result.stable_level, result.long_press, result.short_press};

endmodule

`default_nettype wire

// ----- rtl/bdpc_in_reg.sv -----
`default_nettype none

module bdpc_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  bdpc_pkg::item_t s_item,
  output logic           item_valid,
  output bdpc_pkg::item_t item,
  input  logic           pop
);
  import bdpc_pkg::*;

  // Take a new request whenever the slot is empty or drains this cycle.
  assign s_ready = !item_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bdpc_core.sv -----
`default_nettype none

module bdpc_core (
  input  logic             clk,
  input  logic             rst,
  input  bdpc_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  bdpc_pkg::item_t  in_item,
  output logic             in_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output bdpc_pkg::result_t out_result
);
  import bdpc_pkg::*;

  logic             previous_raw, previous_raw_next;
  logic             debounced_level, debounced_level_next;
  logic [TimeW-1:0] change_time, change_time_next;
  logic [TimeW-1:0] press_time, press_time_next;
  logic             long_reported, long_reported_next;

  logic             raw_changed;
  logic [TimeW-1:0] settle_elapsed;
  logic             level_update;
  logic             press_event;
  logic             release_event;
  logic [TimeW-1:0] hold_old;
  logic [TimeW-1:0] hold_next;
  logic             long_armed;
  logic             short_hit;
  logic             long_hit;
  logic [TimeW-1:0] debounce_ext;
  logic [TimeW-1:0] long_ext;

  assign in_pop = in_valid && (!out_valid || out_ready);

  always_comb begin
    debounce_ext = {{(TimeW-CfgW){1'b0}}, cfg.debounce_window_ms};
    long_ext     = {{(TimeW-CfgW){1'b0}}, cfg.hold_limit_ms};

    raw_changed       = in_item.raw_level != previous_raw;
    previous_raw_next = in_item.raw_level;
    change_time_next  = raw_changed ? in_item.time_ms : change_time;
    settle_elapsed    = raw_changed ? '0 : in_item.time_ms - change_time;

    level_update  = (settle_elapsed > debounce_ext) && (in_item.raw_level != debounced_level);
    press_event   = level_update && !in_item.raw_level;
    release_event = level_update && in_item.raw_level;

    debounced_level_next = level_update ? in_item.raw_level : debounced_level;
    press_time_next      = press_event ? in_item.time_ms : press_time;

    hold_old   = in_item.time_ms - press_time;
    hold_next  = press_event ? '0 : hold_old;
    long_armed = press_event ? 1'b0 : long_reported;

    short_hit = release_event && !long_reported && (hold_old < long_ext);
    long_hit  = !debounced_level_next && !long_armed && (hold_next >= long_ext);

    long_reported_next = long_armed || long_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw    <= 1'b1;
      debounced_level <= 1'b1;
      change_time     <= '0;
      press_time      <= '0;
      long_reported   <= 1'b0;
    end else if (in_pop) begin
      previous_raw    <= previous_raw_next;
      debounced_level <= debounced_level_next;
      change_time     <= change_time_next;
      press_time      <= press_time_next;
      long_reported   <= long_reported_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      out_result.short_press  <= short_hit;
      out_result.long_press   <= long_hit;
      out_result.stable_level <= debounced_level_next;
    end
  end

  a_press_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.short_press && out_result.long_press))
    else $error("short and long press in one result");

  a_short_on_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.short_press) |-> out_result.stable_level)
    else $error("short press without released level");

  a_long_while_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.long_press) |-> !out_result.stable_level)
    else $error("long press without pressed level");

  a_stable_tracks_state: assert property (@(posedge clk) disable iff (rst)
    $past(in_pop) |-> (out_result.stable_level == debounced_level))
    else $error("result level differs from debounced state");

endmodule

`default_nettype wire
